>>> rtl/calendar_seconds_converter_defines.svh
// ----------------------------------------------------------------------------
// Calendar seconds converter assertion macros
// Shared property forms for the converter's checker.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_SECONDS_CONVERTER_DEFINES_SVH
`define CALENDAR_SECONDS_CONVERTER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define CSC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CSC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/csc_pkg.sv
// ----------------------------------------------------------------------------
// csc_pkg
// Types, constants and calendar tables of the calendar seconds converter.
// ----------------------------------------------------------------------------
`default_nettype none

package csc_pkg;

	localparam int BASE_YEAR = 1970;
	localparam int YEAR_SPAN = 128;

	localparam int WALK_W = 8;

	localparam logic [11:0]       BASE_YEAR_Y   = 12'(BASE_YEAR);
	localparam logic [6:0]        BASE_MOD100   = 7'(BASE_YEAR % 100);
	localparam logic [8:0]        BASE_MOD400   = 9'(BASE_YEAR % 400);
	localparam logic [WALK_W-1:0] YEAR_SPAN_CNT = WALK_W'(YEAR_SPAN);

	localparam logic [31:0] SEC_PER_DAY  = 32'd86400;
	localparam logic [31:0] SEC_PER_HOUR = 32'd3600;
	localparam logic [31:0] SEC_PER_MIN  = 32'd60;
	localparam logic [31:0] SUM_START    = 32'd0 - SEC_PER_DAY;
	localparam logic [31:0] YEARS_400    = 32'd400;
	localparam logic [31:0] YEARS_100    = 32'd100;

	// quotient bit counts, top bit index
	localparam logic [2:0] K_DAY_TOP  = 3'd4;
	localparam logic [2:0] K_HOUR_TOP = 3'd4;
	localparam logic [2:0] K_MIN_TOP  = 3'd5;

	// field add order for date to seconds
	localparam logic [2:0] FADD_DAY  = 3'd3;
	localparam logic [2:0] FADD_HOUR = 3'd2;
	localparam logic [2:0] FADD_MIN  = 3'd1;
	localparam logic [2:0] FADD_SEC  = 3'd0;

	typedef struct packed {
		logic        func;
		logic [31:0] seconds_in;
		logic [11:0] year_in;
		logic [3:0]  month_in;
		logic [4:0]  day_in;
		logic [4:0]  hour_in;
		logic [5:0]  minute_in;
		logic [5:0]  second_in;
	} csc_req_t;

	typedef struct packed {
		logic [31:0] seconds_out;
		logic [11:0] year_out;
		logic [3:0]  month_out;
		logic [4:0]  day_out;
		logic [4:0]  hour_out;
		logic [5:0]  minute_out;
		logic [5:0]  second_out;
		logic        out_of_range;
	} csc_res_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_YEAR,
		S_MONTH,
		S_DDIV,
		S_HDIV,
		S_MDIV,
		S_MOD400,
		S_MOD100,
		S_YSUM,
		S_MSUM,
		S_FADD,
		S_DONE
	} csc_state_t;

	function automatic logic [31:0] year_secs(input logic leap);
		return leap ? 32'd31622400 : 32'd31536000;
	endfunction

	// seconds in month m; codes 13 to 15 count as 31 days
	function automatic logic [31:0] month_secs(input logic [3:0] m, input logic leap);
		logic [31:0] s;
		case (m)
			4'd2: begin
				s = leap ? 32'd2505600 : 32'd2419200;
			end
			4'd4, 4'd6, 4'd9, 4'd11: begin
				s = 32'd2592000;
			end
			default: begin
				s = 32'd2678400;
			end
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

>>> rtl/calendar_seconds_converter.sv
// ----------------------------------------------------------------------------
// calendar_seconds_converter
// Seconds since the base year to Gregorian date and time, and back.
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// req       in         req_valid / req_ready  req (csc_req_t)
// res       out        res_valid / res_ready  res (csc_res_t)
//
// One request at a time on a single 32-bit add/subtract unit.
// func 0: years walked, months walked, 16 divide steps for day, hour and
//   minute, then the finish; out of range once the year span is walked.
// func 1: year_in reduced mod 400 and mod 100 for its leap rule, years
//   summed, months summed, the four fields added, then the finish.
// req_ready only in idle; a held result stalls the finish cycle only.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_seconds_converter (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire csc_pkg::csc_req_t req,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output csc_pkg::csc_res_t      res
);

	csc_pkg::csc_state_t state_q, state_d;
	logic                res_valid_q, res_valid_d;
	csc_pkg::csc_res_t   res_q, res_d;
	logic                load_res;

	csc_pkg::csc_req_t           req_q;
	logic [31:0]                 acc_q, acc_d;
	logic [11:0]                 y_q, y_d;
	logic [6:0]                  c100_q, c100_d;
	logic [8:0]                  c400_q, c400_d;
	logic [csc_pkg::WALK_W-1:0]  walked_q, walked_d;
	logic [3:0]                  m_q, m_d;
	logic [2:0]                  k_q, k_d;
	logic [4:0]                  day_q, day_d;
	logic [4:0]                  hour_q, hour_d;
	logic [5:0]                  min_q, min_d;
	logic                        oor_q, oor_d;
	logic                        z400_q, z400_d;
	logic                        leap_in_q, leap_in_d;

	logic        leap_y;
	logic [31:0] alu_b;
	logic        alu_sub;
	logic [32:0] alu_sum;
	logic [31:0] alu_r;
	logic        ge;

	assign leap_y = ((y_q[1:0] == 2'b00) && (c100_q != '0)) || (c400_q == '0);

	assign alu_sum = {1'b0, acc_q} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + 33'(alu_sub);
	assign alu_r   = alu_sum[31:0];
	assign ge      = alu_sum[32];

	assign req_ready = (state_q == csc_pkg::S_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		state_d   = state_q;
		acc_d     = acc_q;
		y_d       = y_q;
		c100_d    = c100_q;
		c400_d    = c400_q;
		walked_d  = walked_q;
		m_d       = m_q;
		k_d       = k_q;
		day_d     = day_q;
		hour_d    = hour_q;
		min_d     = min_q;
		oor_d     = oor_q;
		z400_d    = z400_q;
		leap_in_d = leap_in_q;
		alu_b     = '0;
		alu_sub   = 1'b1;
		load_res  = 1'b0;
		res_d     = '0;

		case (state_q)
			csc_pkg::S_IDLE: begin
				if (req_valid) begin
					acc_d    = req.func ? 32'(req.year_in) : req.seconds_in;
					y_d      = csc_pkg::BASE_YEAR_Y;
					c100_d   = csc_pkg::BASE_MOD100;
					c400_d   = csc_pkg::BASE_MOD400;
					walked_d = '0;
					m_d      = 4'd1;
					oor_d    = 1'b0;
					state_d  = req.func ? csc_pkg::S_MOD400 : csc_pkg::S_YEAR;
				end
			end
			csc_pkg::S_YEAR: begin
				alu_b = csc_pkg::year_secs(leap_y);
				if (walked_q == csc_pkg::YEAR_SPAN_CNT) begin
					oor_d   = 1'b1;
					state_d = csc_pkg::S_DONE;
				end else if (ge) begin
					acc_d    = alu_r;
					y_d      = y_q + 12'd1;
					c100_d   = (c100_q == 7'd99) ? '0 : c100_q + 7'd1;
					c400_d   = (c400_q == 9'd399) ? '0 : c400_q + 9'd1;
					walked_d = walked_q + csc_pkg::WALK_W'(1);
				end else begin
					state_d = csc_pkg::S_MONTH;
				end
			end
			csc_pkg::S_MONTH: begin
				alu_b = csc_pkg::month_secs(m_q, leap_y);
				if ((m_q < 4'd12) && ge) begin
					acc_d = alu_r;
					m_d   = m_q + 4'd1;
				end else begin
					k_d     = csc_pkg::K_DAY_TOP;
					state_d = csc_pkg::S_DDIV;
				end
			end
			csc_pkg::S_DDIV: begin
				alu_b = csc_pkg::SEC_PER_DAY << k_q;
				if (ge) begin
					acc_d = alu_r;
				end
				day_d = {day_q[3:0], ge};
				if (k_q == '0) begin
					k_d     = csc_pkg::K_HOUR_TOP;
					state_d = csc_pkg::S_HDIV;
				end else begin
					k_d = k_q - 3'd1;
				end
			end
			csc_pkg::S_HDIV: begin
				alu_b = csc_pkg::SEC_PER_HOUR << k_q;
				if (ge) begin
					acc_d = alu_r;
				end
				hour_d = {hour_q[3:0], ge};
				if (k_q == '0) begin
					k_d     = csc_pkg::K_MIN_TOP;
					state_d = csc_pkg::S_MDIV;
				end else begin
					k_d = k_q - 3'd1;
				end
			end
			csc_pkg::S_MDIV: begin
				alu_b = csc_pkg::SEC_PER_MIN << k_q;
				if (ge) begin
					acc_d = alu_r;
				end
				min_d = {min_q[4:0], ge};
				if (k_q == '0) begin
					state_d = csc_pkg::S_DONE;
				end else begin
					k_d = k_q - 3'd1;
				end
			end
			csc_pkg::S_MOD400: begin
				alu_b = csc_pkg::YEARS_400;
				if (ge) begin
					acc_d = alu_r;
				end else begin
					z400_d  = (acc_q == '0);
					state_d = csc_pkg::S_MOD100;
				end
			end
			csc_pkg::S_MOD100: begin
				alu_b = csc_pkg::YEARS_100;
				if (ge) begin
					acc_d = alu_r;
				end else begin
					leap_in_d = ((req_q.year_in[1:0] == 2'b00) && (acc_q != '0)) || z400_q;
					acc_d     = csc_pkg::SUM_START;
					state_d   = csc_pkg::S_YSUM;
				end
			end
			csc_pkg::S_YSUM: begin
				alu_sub = 1'b0;
				alu_b   = csc_pkg::year_secs(leap_y);
				if (y_q < req_q.year_in) begin
					acc_d  = alu_r;
					y_d    = y_q + 12'd1;
					c100_d = (c100_q == 7'd99) ? '0 : c100_q + 7'd1;
					c400_d = (c400_q == 9'd399) ? '0 : c400_q + 9'd1;
				end else begin
					state_d = csc_pkg::S_MSUM;
				end
			end
			csc_pkg::S_MSUM: begin
				alu_sub = 1'b0;
				alu_b   = csc_pkg::month_secs(m_q, leap_in_q);
				if (m_q < req_q.month_in) begin
					acc_d = alu_r;
					m_d   = m_q + 4'd1;
				end else begin
					k_d     = csc_pkg::FADD_DAY;
					state_d = csc_pkg::S_FADD;
				end
			end
			csc_pkg::S_FADD: begin
				alu_sub = 1'b0;
				case (k_q)
					csc_pkg::FADD_DAY: begin
						alu_b = 32'(req_q.day_in) * csc_pkg::SEC_PER_DAY;
					end
					csc_pkg::FADD_HOUR: begin
						alu_b = 32'(req_q.hour_in) * csc_pkg::SEC_PER_HOUR;
					end
					csc_pkg::FADD_MIN: begin
						alu_b = 32'(req_q.minute_in) * csc_pkg::SEC_PER_MIN;
					end
					default: begin
						alu_b = 32'(req_q.second_in);
					end
				endcase
				acc_d = alu_r;
				if (k_q == csc_pkg::FADD_SEC) begin
					state_d = csc_pkg::S_DONE;
				end else begin
					k_d = k_q - 3'd1;
				end
			end
			csc_pkg::S_DONE: begin
				if (!res_valid_q || res_ready) begin
					load_res = 1'b1;
					state_d  = csc_pkg::S_IDLE;
				end
				if (req_q.func) begin
					res_d.seconds_out = acc_q;
				end else if (oor_q) begin
					res_d.out_of_range = 1'b1;
				end else begin
					res_d.year_out   = y_q;
					res_d.month_out  = m_q;
					res_d.day_out    = day_q + 5'd1;
					res_d.hour_out   = hour_q;
					res_d.minute_out = min_q;
					res_d.second_out = acc_q[5:0];
				end
			end
			default: begin
				state_d = csc_pkg::S_IDLE;
			end
		endcase

		res_valid_d = load_res | (res_valid_q & ~res_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= csc_pkg::S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			res_valid_q <= res_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q <= req;
		end
		if (load_res) begin
			res_q <= res_d;
		end
		acc_q     <= acc_d;
		y_q       <= y_d;
		c100_q    <= c100_d;
		c400_q    <= c400_d;
		walked_q  <= walked_d;
		m_q       <= m_d;
		k_q       <= k_d;
		day_q     <= day_d;
		hour_q    <= hour_d;
		min_q     <= min_d;
		oor_q     <= oor_d;
		z400_q    <= z400_d;
		leap_in_q <= leap_in_d;
	end

endmodule

`default_nettype wire

>>> rtl/csc_checker.sv
// ----------------------------------------------------------------------------
// csc_checker
// Port-level checks of the calendar seconds converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "calendar_seconds_converter_defines.svh"

module csc_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              req_valid,
	input wire logic              req_ready,
	input wire csc_pkg::csc_req_t req,
	input wire logic              res_valid,
	input wire logic              res_ready,
	input wire csc_pkg::csc_res_t res
);

	// a held result does not change
	`CSC_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res), "result changed while stalled")

	// one request in flight: busy right after accept
	`CSC_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready, "ready right after a request")

	// out of range result carries no date and no seconds
	`CSC_ASSERT_NOW(a_oor_zero, res_valid && res.out_of_range, (res.seconds_out == '0) && (res.year_out == '0) && (res.month_out == '0) && (res.day_out == '0), "out of range result not cleared")

	// a date result is well formed
	`CSC_ASSERT_NOW(a_date_sane, res_valid && (res.year_out != '0), (res.seconds_out == '0) && !res.out_of_range && (res.month_out >= 4'd1) && (res.month_out <= 4'd12) && (res.day_out != '0) && (res.hour_out <= 5'd23) && (res.minute_out <= 6'd59) && (res.second_out <= 6'd59), "malformed date result")

endmodule

bind calendar_seconds_converter csc_checker u_csc_checker (.*);

`default_nettype wire

>>> dv/calendar_seconds_converter_test.sv
// ----------------------------------------------------------------------------
// calendar_seconds_converter_test
// Drives seconds-to-date and date-to-seconds requests through the converter
// under bursty request traffic and a stalling result side, and checks every
// result against a calendar model kept inside the scoreboard.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module calendar_seconds_converter_test;

	localparam int unsigned NUM_RANDOM  = 1450;
	localparam int unsigned STALL_LIMIT = 20000;
	localparam int unsigned DRAIN_WAIT  = 300;

	typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_BLOCKS} rx_mode_t;

	class calendar_scoreboard;
		csc_pkg::csc_res_t expected_q[$];
		int unsigned       mismatches;

		function new();
			mismatches = 0;
		endfunction

		static function bit is_leap_yr(int unsigned y);
			return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		endfunction

		static function logic [31:0] year_len(int unsigned y);
			return (is_leap_yr(y) ? 32'd366 : 32'd365) * csc_pkg::SEC_PER_DAY;
		endfunction

		static function logic [31:0] month_len(int unsigned m, int unsigned y);
			logic [31:0] days;
			if (m == 4 || m == 6 || m == 9 || m == 11)
				days = 32'd30;
			else if (m == 2)
				days = is_leap_yr(y) ? 32'd29 : 32'd28;
			else
				days = 32'd31;
			return days * csc_pkg::SEC_PER_DAY;
		endfunction

		static function logic [31:0] span_end();
			logic [31:0] total;
			total = '0;
			for (int unsigned i = 0; i < csc_pkg::YEAR_SPAN; i++)
				total += year_len(csc_pkg::BASE_YEAR + i);
			return total;
		endfunction

		static function csc_pkg::csc_res_t convert(csc_pkg::csc_req_t r);
			csc_pkg::csc_res_t e;
			logic [31:0]       rem;
			logic [31:0]       sum;
			int unsigned       y;
			int unsigned       m;
			int unsigned       walked;
			e = '0;
			if (r.func == 1'b0) begin
				rem = r.seconds_in;
				y = csc_pkg::BASE_YEAR;
				walked = 0;
				while (walked < csc_pkg::YEAR_SPAN && rem >= year_len(y)) begin
					rem -= year_len(y);
					y++;
					walked++;
				end
				if (walked >= csc_pkg::YEAR_SPAN) begin
					e.out_of_range = 1'b1;
				end else begin
					m = 1;
					while (m < 12 && rem >= month_len(m, y)) begin
						rem -= month_len(m, y);
						m++;
					end
					e.year_out = 12'(y);
					e.month_out = 4'(m);
					e.day_out = 5'(rem / csc_pkg::SEC_PER_DAY + 32'd1);
					rem = rem % csc_pkg::SEC_PER_DAY;
					e.hour_out = 5'(rem / csc_pkg::SEC_PER_HOUR);
					rem = rem % csc_pkg::SEC_PER_HOUR;
					e.minute_out = 6'(rem / csc_pkg::SEC_PER_MIN);
					e.second_out = 6'(rem % csc_pkg::SEC_PER_MIN);
				end
			end else begin
				sum = '0;
				for (y = csc_pkg::BASE_YEAR; y < r.year_in; y++)
					sum += year_len(y);
				for (m = 1; m < r.month_in; m++)
					sum += month_len(m, r.year_in);
				sum += (32'(r.day_in) - 32'd1) * csc_pkg::SEC_PER_DAY;
				sum += 32'(r.hour_in) * csc_pkg::SEC_PER_HOUR;
				sum += 32'(r.minute_in) * csc_pkg::SEC_PER_MIN;
				sum += 32'(r.second_in);
				e.seconds_out = sum;
			end
			return e;
		endfunction

		function void note_request(csc_pkg::csc_req_t r);
			expected_q.push_back(convert(r));
		endfunction

		function void check_field(string name, logic [31:0] e, logic [31:0] a);
			if (e !== a) begin
				$display("%0t: %s expected %0d got %0d", $time, name, e, a);
				mismatches++;
			end
		endfunction

		function void check_result(csc_pkg::csc_res_t got);
			csc_pkg::csc_res_t e;
			if (expected_q.size() == 0) begin
				$display("%0t: result with no request outstanding, got %h", $time, got);
				mismatches++;
				return;
			end
			e = expected_q.pop_front();
			check_field("seconds_out", e.seconds_out, got.seconds_out);
			check_field("year_out", 32'(e.year_out), 32'(got.year_out));
			check_field("month_out", 32'(e.month_out), 32'(got.month_out));
			check_field("day_out", 32'(e.day_out), 32'(got.day_out));
			check_field("hour_out", 32'(e.hour_out), 32'(got.hour_out));
			check_field("minute_out", 32'(e.minute_out), 32'(got.minute_out));
			check_field("second_out", 32'(e.second_out), 32'(got.second_out));
			check_field("out_of_range", 32'(e.out_of_range), 32'(got.out_of_range));
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              req_valid;
	logic              req_ready;
	csc_pkg::csc_req_t req;
	logic              res_valid;
	logic              res_ready;
	csc_pkg::csc_res_t res;

	calendar_scoreboard sb = new();
	csc_pkg::csc_req_t  stim_q[$];

	rx_mode_t    rx_mode = RX_OPEN;
	int unsigned rx_left = 0;
	int unsigned rx_hold = 0;

	calendar_seconds_converter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic csc_pkg::csc_req_t noise_req();
		csc_pkg::csc_req_t r;
		r.func = 1'($urandom);
		r.seconds_in = $urandom;
		r.year_in = 12'($urandom);
		r.month_in = 4'($urandom);
		r.day_in = 5'($urandom);
		r.hour_in = 5'($urandom);
		r.minute_in = 6'($urandom);
		r.second_in = 6'($urandom);
		return r;
	endfunction

	function automatic csc_pkg::csc_req_t secs_req(logic [31:0] s);
		csc_pkg::csc_req_t r;
		r = noise_req();
		r.func = 1'b0;
		r.seconds_in = s;
		return r;
	endfunction

	function automatic csc_pkg::csc_req_t date_req(int unsigned y, int unsigned mo,
			int unsigned d, int unsigned hh, int unsigned mm, int unsigned ss);
		csc_pkg::csc_req_t r;
		r = noise_req();
		r.func = 1'b1;
		r.year_in = 12'(y);
		r.month_in = 4'(mo);
		r.day_in = 5'(d);
		r.hour_in = 5'(hh);
		r.minute_in = 6'(mm);
		r.second_in = 6'(ss);
		return r;
	endfunction

	function automatic logic [31:0] date_secs(int unsigned y, int unsigned mo, int unsigned d);
		return calendar_scoreboard::convert(date_req(y, mo, d, 0, 0, 0)).seconds_out;
	endfunction

	function automatic csc_pkg::csc_req_t random_req();
		csc_pkg::csc_req_t r;
		int unsigned       pick;
		logic [31:0]       span;
		span = calendar_scoreboard::span_end();
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			r = secs_req($urandom_range(0, span - 1));
		end else if (pick < 40) begin
			r = secs_req(date_secs($urandom_range(csc_pkg::BASE_YEAR,
				csc_pkg::BASE_YEAR + csc_pkg::YEAR_SPAN - 1),
				$urandom_range(1, 12), 1) + $urandom_range(0, 8) - 32'd4);
		end else if (pick < 46) begin
			r = secs_req($urandom);
		end else if (pick < 50) begin
			r = secs_req(span - 32'd8 + $urandom_range(0, 15));
		end else if (pick < 88) begin
			r = date_req($urandom_range(csc_pkg::BASE_YEAR,
				csc_pkg::BASE_YEAR + csc_pkg::YEAR_SPAN - 1),
				$urandom_range(1, 12), $urandom_range(1, 31), $urandom_range(0, 23),
				$urandom_range(0, 59), $urandom_range(0, 59));
		end else if (pick < 97) begin
			r = noise_req();
			r.func = 1'b1;
			r.year_in = 12'($urandom_range(0, 2200));
		end else begin
			r = noise_req();
			r.func = 1'b1;
		end
		return r;
	endfunction

	task automatic send_req(csc_pkg::csc_req_t r);
		@(negedge clk);
		req <= r;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (!req_ready);
		sb.note_request(r);
	endtask

	task automatic idle_gap(int unsigned cycles);
		@(negedge clk);
		req_valid <= 1'b0;
		req <= noise_req();
		repeat (cycles - 1) @(negedge clk);
	endtask

	// result side: the stall pattern switches among four modes, picked at random
	always @(negedge clk) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode <= rx_mode_t'($urandom_range(0, 3));
				rx_left <= $urandom_range(40, 400);
			end else begin
				rx_left <= rx_left - 1;
			end
			case (rx_mode)
				RX_OPEN: begin
					res_ready <= 1'b1;
				end
				RX_RANDOM: begin
					res_ready <= 1'($urandom_range(0, 1));
				end
				RX_SPARSE: begin
					res_ready <= ($urandom_range(0, 7) == 0);
				end
				default: begin
					if (rx_hold == 0) begin
						res_ready <= ~res_ready;
						rx_hold <= $urandom_range(0, 40);
					end else begin
						rx_hold <= rx_hold - 1;
					end
				end
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			sb.check_result(res);
	end

	initial begin
		int unsigned idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (res_valid && res_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		logic [31:0] span;
		int unsigned burst_left;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		span = calendar_scoreboard::span_end();

		// seconds to date: edges, leap days, span boundary
		stim_q.push_back(secs_req(32'd0));
		stim_q.push_back(secs_req(32'd86399));
		stim_q.push_back(secs_req(32'd86400));
		stim_q.push_back(secs_req(date_secs(1972, 2, 29) + 32'd86399));
		stim_q.push_back(secs_req(date_secs(2000, 1, 1) - 32'd1));
		stim_q.push_back(secs_req(date_secs(2000, 3, 1) - 32'd1));
		stim_q.push_back(secs_req(date_secs(2096, 12, 31) + 32'd86399));
		stim_q.push_back(secs_req(span - 32'd1));
		stim_q.push_back(secs_req(span));
		stim_q.push_back(secs_req(32'hFFFF_FFFF));
		// date to seconds: base, leap rules, odd fields, wrap
		stim_q.push_back(date_req(1970, 1, 1, 0, 0, 0));
		stim_q.push_back(date_req(2097, 12, 31, 23, 59, 59));
		stim_q.push_back(date_req(2000, 2, 29, 12, 30, 30));
		stim_q.push_back(date_req(2101, 3, 1, 0, 0, 0));
		stim_q.push_back(date_req(0, 1, 1, 0, 0, 0));
		stim_q.push_back(date_req(1969, 6, 15, 1, 2, 3));
		stim_q.push_back(date_req(1980, 0, 1, 0, 0, 0));
		stim_q.push_back(date_req(1980, 15, 1, 0, 0, 0));
		stim_q.push_back(date_req(1970, 1, 0, 0, 0, 0));
		stim_q.push_back(date_req(1999, 12, 31, 31, 63, 63));
		stim_q.push_back(date_req(4095, 15, 31, 31, 63, 63));
		for (int unsigned i = 0; i < NUM_RANDOM; i++)
			stim_q.push_back(random_req());

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		burst_left = $urandom_range(1, 12);
		foreach (stim_q[i]) begin
			send_req(stim_q[i]);
			burst_left--;
			if (burst_left == 0) begin
				idle_gap(($urandom_range(0, 3) == 0) ? $urandom_range(50, 300)
					: $urandom_range(1, 8));
				burst_left = $urandom_range(1, 12);
			end
		end
		@(negedge clk);
		req_valid <= 1'b0;

		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (sb.mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
